/* hw/rtl/vn3_pkg.sv */
`timescale 1ns / 1ps

package vn3_pkg;

  // coordinate format
  localparam int COORD_W   = 24;
  localparam int FRAC_BITS = 16;
  localparam int CELL_W    = COORD_W - FRAC_BITS;
  localparam int SEED_W    = 32;
  localparam int OUT_W     = 17;
  localparam int AXES      = 3;
  localparam int CORNERS   = 8;

  // pipeline depth, input register stage 1 to output register
  localparam int NUM_STAGES = 11;

  // hash constants
  localparam logic [31:0] HASH_KX  = 32'd1619;
  localparam logic [31:0] HASH_KY  = 32'd31337;
  localparam logic [31:0] HASH_KZ  = 32'd6971;
  localparam logic [31:0] HASH_KS  = 32'd1013;
  localparam logic [31:0] HASH_MUL = 32'd60493;

  // smoothstep 3 - 2t scaled by 2^16, and corner value bias
  localparam logic [17:0]      SMOOTH_K    = 18'd196608;
  localparam logic [OUT_W-1:0] CORNER_BIAS = 17'd65535;

  typedef logic signed [OUT_W-1:0] cval_t;
  typedef logic signed [34:0]      lprod_t;

  // stage enables of the corner hash pipe
  typedef struct packed {
    logic mix_en;
    logic mul_en;
    logic out_en;
  } hash_ctl_t;

  // fraction bits to q0.16
  function automatic logic [15:0] frac16(input logic [FRAC_BITS-1:0] f);
    logic [FRAC_BITS+15:0] w;
    w = {f, 16'h0000};
    return 16'(w >> FRAC_BITS);
  endfunction

  // lattice offset added to the base hash sum for one cell corner
  function automatic logic [31:0] corner_ofs(input logic [2:0] idx);
    logic [31:0] o;
    o = 32'd0;
    if (idx[0]) o = o + HASH_KX;
    if (idx[1]) o = o + HASH_KY;
    if (idx[2]) o = o + HASH_KZ;
    return o;
  endfunction

  // first half of a lerp: (b - a) * s
  function automatic lprod_t lerp_prod(input cval_t a, input cval_t b, input logic [15:0] s);
    logic signed [17:0] diff;
    diff = 18'(b) - 18'(a);
    return 35'(diff) * 35'($signed({1'b0, s}));
  endfunction

  // second half: a + floor(p / 65536)
  function automatic cval_t lerp_fin(input cval_t a, input lprod_t p);
    return a + OUT_W'(p >>> 16);
  endfunction

endpackage

/* hw/rtl/vn3_hash.sv */
`timescale 1ns / 1ps

module vn3_hash import vn3_pkg::*; (
  input  logic        clk_i,
  input  hash_ctl_t   ctl_i,
  input  logic [31:0] base_i,
  input  logic [31:0] ofs_i,
  output cval_t       value_o
);

  logic [31:0] mix_d, mix_q;
  logic [31:0] mul_d, mul_q;
  logic [31:0] fold;
  cval_t       value_d, value_q;

  // corner sum and first xor-shift
  always_comb begin
    mix_d = base_i + ofs_i;
    mix_d = mix_d ^ (mix_d >> 13);
  end

  // multiply step, kept modulo 2^32
  assign mul_d = 32'(mix_q * HASH_MUL);

  // second xor-shift, then 2h - 65535
  always_comb begin
    fold    = mul_q ^ (mul_q >> 17);
    value_d = $signed({fold[15:0], 1'b0} - CORNER_BIAS);
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.mix_en) mix_q <= mix_d;
    if (ctl_i.mul_en) mul_q <= mul_d;
    if (ctl_i.out_en) value_q <= value_d;
  end

  assign value_o = value_q;

endmodule

/* hw/rtl/value_noise_3d_top.sv */
`timescale 1ns / 1ps

// 3d value noise, one sample per input beat.
// input channel: in_valid_i / in_stall_o with coord_x_i, coord_y_i, coord_z_i
// (signed, FRAC_BITS fraction bits) and noise_seed_i. output channel:
// out_valid_o / out_stall_i with noise_value_o (-65535..65535 for -1..1).
// a beat moves when valid is high and stall is low on that channel.
// the work is an 11-stage pipeline (hash products, hash sum and smoothstep,
// three hash stages, then x, y and z lerps as multiply and add stages each).
// throughput is one beat per cycle while out_stall_i is low; a new beat is
// taken every cycle while results drain. when out_stall_i is held, the
// pipeline closes up its bubbles and in_stall_o rises only once every stage
// holds a beat; nothing is dropped or repeated. reset clears all stage valid
// bits, so the output is idle and the input is ready right after reset.
module value_noise_3d_top import vn3_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic [SEED_W-1:0]         noise_seed_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output cval_t                     noise_value_o
);

  logic [NUM_STAGES:1] vld_d, vld_q;
  logic [NUM_STAGES:1] en;
  logic                in_acc, out_acc;

  // stage enables: a stage loads when it is empty or its beat moves on
  always_comb begin
    en[NUM_STAGES] = !vld_q[NUM_STAGES] || !out_stall_i;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_comb begin
    vld_d[1] = en[1] ? in_valid_i : vld_q[1];
    for (int k = 2; k <= NUM_STAGES; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !en[1];
  assign out_valid_o = vld_q[NUM_STAGES];
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_acc     = out_valid_o && !out_stall_i;

  // stage 1: split coordinates, hash products, t*t and 3 - 2t
  logic signed [COORD_W-1:0] crd [AXES];
  logic signed [CELL_W-1:0]  flr [AXES];
  logic [31:0]               cell32 [AXES];
  logic [15:0]               tfr [AXES];
  logic [31:0]               pax_d [AXES];
  logic [31:0]               pax_q [AXES];
  logic [31:0]               pseed_d, pseed_q;
  logic [31:0]               tt_d [AXES];
  logic [31:0]               tt_q [AXES];
  logic [17:0]               kk_d [AXES];
  logic [17:0]               kk_q [AXES];

  assign crd[0] = coord_x_i;
  assign crd[1] = coord_y_i;
  assign crd[2] = coord_z_i;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      flr[a]    = crd[a][COORD_W-1:FRAC_BITS];
      cell32[a] = 32'(flr[a]);
      tfr[a]    = frac16(crd[a][FRAC_BITS-1:0]);
      tt_d[a]   = 32'(tfr[a]) * 32'(tfr[a]);
      kk_d[a]   = SMOOTH_K - {1'b0, tfr[a], 1'b0};
    end
    pax_d[0] = 32'(cell32[0] * HASH_KX);
    pax_d[1] = 32'(cell32[1] * HASH_KY);
    pax_d[2] = 32'(cell32[2] * HASH_KZ);
    pseed_d  = 32'(noise_seed_i * HASH_KS);
  end

  // stage 2: base hash sum and smoothstep product
  logic [31:0] base_d, base_q;
  logic [49:0] sprod [AXES];
  logic [15:0] sm_d [AXES];
  logic [15:0] sm_q [NUM_STAGES-2:2][AXES];

  always_comb begin
    base_d = pax_q[0] + pax_q[1] + pax_q[2] + pseed_q;
    for (int a = 0; a < AXES; a++) begin
      sprod[a] = 50'(tt_q[a]) * 50'(kk_q[a]);
      sm_d[a]  = sprod[a][47:32];
    end
  end

  // stages 3 to 5: corner hashes
  hash_ctl_t hctl;
  cval_t     cv [CORNERS];

  assign hctl.mix_en = en[3];
  assign hctl.mul_en = en[4];
  assign hctl.out_en = en[5];

  for (genvar c = 0; c < CORNERS; c++) begin : g_corner
    vn3_hash u_hash (
      .clk_i   (clk_i),
      .ctl_i   (hctl),
      .base_i  (base_q),
      .ofs_i   (corner_ofs(3'(c))),
      .value_o (cv[c])
    );
  end

  // stage 6: x products; stage 7: x lerps
  lprod_t xp_d [4];
  lprod_t xp_q [4];
  cval_t  xa_q [4];
  cval_t  lx_d [4];
  cval_t  lx_q [4];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      xp_d[i] = lerp_prod(cv[2*i], cv[2*i+1], sm_q[5][0]);
      lx_d[i] = lerp_fin(xa_q[i], xp_q[i]);
    end
  end

  // stage 8: y products; stage 9: y lerps
  lprod_t yp_d [2];
  lprod_t yp_q [2];
  cval_t  ya_q [2];
  cval_t  ly_d [2];
  cval_t  ly_q [2];

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      yp_d[i] = lerp_prod(lx_q[2*i], lx_q[2*i+1], sm_q[7][1]);
      ly_d[i] = lerp_fin(ya_q[i], yp_q[i]);
    end
  end

  // stage 10: z product; stage 11: z lerp into the output register
  lprod_t zp_d, zp_q;
  cval_t  za_q;
  cval_t  out_d, out_q;

  assign zp_d  = lerp_prod(ly_q[0], ly_q[1], sm_q[9][2]);
  assign out_d = lerp_fin(za_q, zp_q);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      pax_q   <= pax_d;
      pseed_q <= pseed_d;
      tt_q    <= tt_d;
      kk_q    <= kk_d;
    end
    if (en[2]) begin
      base_q  <= base_d;
      sm_q[2] <= sm_d;
    end
    for (int k = 3; k <= NUM_STAGES - 2; k++) begin
      if (en[k]) sm_q[k] <= sm_q[k-1];
    end
    if (en[6]) begin
      xp_q <= xp_d;
      for (int i = 0; i < 4; i++) xa_q[i] <= cv[2*i];
    end
    if (en[7]) lx_q <= lx_d;
    if (en[8]) begin
      yp_q <= yp_d;
      for (int i = 0; i < 2; i++) ya_q[i] <= lx_q[2*i];
    end
    if (en[9]) ly_q <= ly_d;
    if (en[10]) begin
      zp_q <= zp_d;
      za_q <= ly_q[0];
    end
    if (en[11]) out_q <= out_d;
  end

  assign noise_value_o = out_q;

  // the input stalls only when every stage is full and the output is held
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> ((&vld_q) && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // beats in flight change only by accepted and delivered beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(vld_q) + $past(out_acc) == $past($countones(vld_q)) + $past(in_acc)))
    else $error("beat lost or duplicated in the pipeline");

  // a delivered sample never takes the one code below -65535
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (noise_value_o != $signed(17'h10000)))
    else $error("noise value out of range");

endmodule
